@@ hw/rtl/ph768_pkg.sv @@
// ----------------------------------------------------------------------------
// ph768_pkg
// Types, constants and the permutation round shared by the hash front end,
// command queue and compression back end.
// ----------------------------------------------------------------------------
`default_nettype none

package ph768_pkg;

	localparam int ROUND_COUNT = 16;
	localparam int RND_W       = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;
	localparam int QDEPTH      = 2;
	localparam int QAW         = $clog2(QDEPTH);
	localparam int RATE_WORDS  = 12;
	localparam int CHAIN_WORDS = 24;
	localparam int PERM_WORDS  = 25;

	typedef logic [63:0] lane_t;
	typedef lane_t [PERM_WORDS-1:0]  perm_t;
	typedef lane_t [CHAIN_WORDS-1:0] chain_t;
	typedef lane_t [RATE_WORDS-1:0]  rate_t;

	localparam lane_t PAD_BIT     = 64'h8000_0000_0000_0000;
	localparam lane_t DOM_PADDED  = 64'h8000_0000_0000_0000;
	localparam lane_t DOM_EXACT   = 64'hC000_0000_0000_0000;
	localparam lane_t CHAIN_LEN   = 64'd768;
	localparam chain_t CHAIN_INIT = {CHAIN_LEN, {(CHAIN_WORDS-1){64'd0}}};
	localparam logic [3:0] POS_LAST   = 4'd11;
	localparam logic [3:0] POS_EXACT  = 4'd8;
	localparam logic [3:0] EMIT_LAST  = 4'd11;

	typedef struct packed {
		lane_t word;
		logic  last;
		logic  full;
		logic  vzero;
	} cmd_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_TAIL,
		B_CLOAD,
		B_CROUND,
		B_CLR,
		B_FLOAD,
		B_FROUND,
		B_EMIT
	} bstate_t;

	typedef enum logic [1:0] {
		P_IDLE,
		P_TAIL,
		P_CLR
	} post_t;

	localparam lane_t ROUND_KEY [16] = '{
		64'hb7e151628aed2a6a, 64'haf82a3cd15dad4d7, 64'h9f4546922bb529ad,
		64'hfeca8c2c576ad359, 64'h3dd51950aed526b1, 64'h7baa32a15daa4d62,
		64'hf7546542bb549ac4, 64'h2ee8cb8d76a9b58b, 64'h5dd1971aed536b16,
		64'hbba32e35daa6d62c, 64'hb7065d63b54d2c5b, 64'hae4cbbcf6a9ad8b5,
		64'h9cd97696d5353169, 64'hf9f2ec25aa6ae2d1, 64'h33a5d94354d545a1,
		64'h674bb286a9aa8b42
	};

	localparam logic [6:0] ROT [25] = '{
		7'd31, 7'd1,  7'd4,  7'd21, 7'd22,
		7'd19, 7'd12, 7'd15, 7'd34, 7'd13,
		7'd28, 7'd35, 7'd58, 7'd9,  7'd23,
		7'd55, 7'd18, 7'd5,  7'd27, 7'd44,
		7'd14, 7'd43, 7'd53, 7'd20, 7'd25
	};

	function automatic lane_t rotl(lane_t x, logic [6:0] n);
		return (x << n) | (x >> (7'd64 - n));
	endfunction

	function automatic lane_t rotr(lane_t x, logic [6:0] n);
		return (x >> n) | (x << (7'd64 - n));
	endfunction

	function automatic perm_t perm_round(perm_t a, lane_t key);
		perm_t b;
		perm_t c;
		perm_t d;
		perm_t e;
		lane_t p;
		lane_t q;
		b = a;
		b[0] = b[0] ^ key;
		for (int i = 0; i < 5; i++) begin
			c[i]      = (b[i] & b[10+i] & b[15+i]) ^ (b[10+i] & b[15+i] & b[20+i])
			          ^ (b[i] & b[20+i]) ^ (b[15+i] & b[20+i]) ^ b[5+i];
			c[5+i]    = (b[5+i] & b[15+i] & b[20+i]) ^ (b[i] & b[5+i]) ^ b[10+i];
			c[10+i]   = (b[5+i] & b[10+i]) ^ b[15+i];
			c[15+i]   = (b[10+i] & b[15+i]) ^ b[20+i];
			c[20+i]   = (b[15+i] & b[20+i]) ^ b[i];
		end
		for (int i = 0; i < 5; i++) begin
			p = '0;
			q = '0;
			for (int j = 0; j < 5; j++) begin
				p = p ^ c[5*i+j];
				q = q ^ rotl(c[5*i+j], ROT[5*i+j]);
			end
			for (int j = 0; j < 5; j++) begin
				d[5*i+j] = c[5*i+j] ^ rotr(p, ROT[5*i+j]) ^ q;
			end
		end
		for (int i = 0; i < 5; i++) begin
			for (int j = 0; j < 5; j++) begin
				e[5*i+j] = d[((i + 2*j) % 5) * 5 + ((3*i + 3*j) % 5)];
			end
		end
		return e;
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/ph768_front.sv @@
// ----------------------------------------------------------------------------
// ph768_front
// Accepts message words, saturates the valid count and applies the bit
// padding to a partial last word before queueing it.
// ----------------------------------------------------------------------------
`default_nettype none

module ph768_front (
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [71:0]       s_tdata,   // data_word[63:0], valid_bits[70:64], zero
	input  wire logic              s_tlast,
	input  wire logic              q_full,
	output logic                   q_push,
	output ph768_pkg::cmd_t        q_cmd
);

	ph768_pkg::lane_t w;
	logic [6:0]       v;
	logic [5:0]       vs;
	ph768_pkg::lane_t padded;

	assign w  = s_tdata[63:0];
	assign v  = s_tdata[70:64];
	assign vs = v[5:0];
	assign padded = (w & ~({64{1'b1}} >> vs)) | (ph768_pkg::PAD_BIT >> vs);

	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;

	always_comb begin
		q_cmd.last  = s_tlast;
		q_cmd.full  = !s_tlast || v[6];
		q_cmd.vzero = (v == 7'd0);
		q_cmd.word  = q_cmd.full ? w : padded;
	end

endmodule

`default_nettype wire

@@ hw/rtl/ph768_queue.sv @@
// ----------------------------------------------------------------------------
// ph768_queue
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ph768_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire ph768_pkg::cmd_t push_cmd,
	input  wire logic            pop,
	output ph768_pkg::cmd_t      pop_cmd,
	output logic                 full,
	output logic                 empty
);

	ph768_pkg::cmd_t                mem_q [ph768_pkg::QDEPTH];
	logic [ph768_pkg::QAW-1:0]      wr_q;
	logic [ph768_pkg::QAW-1:0]      rd_q;
	logic [ph768_pkg::QAW:0]        cnt_q;

	assign full    = (cnt_q == (ph768_pkg::QAW+1)'(ph768_pkg::QDEPTH));
	assign empty   = (cnt_q == '0);
	assign pop_cmd = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_cmd;
	end

endmodule

`default_nettype wire

@@ hw/rtl/ph768_back.sv @@
// ----------------------------------------------------------------------------
// ph768_back
// Rate buffer, chaining state and block counter; runs compressions and the
// finalization one permutation round per cycle and streams the digest.
// ----------------------------------------------------------------------------
`default_nettype none

module ph768_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire ph768_pkg::cmd_t cmd,
	input  wire logic            q_empty,
	output logic                 q_pop,
	output logic                 m_tvalid,
	input  wire logic            m_tready,
	output logic [63:0]          m_tdata,   // digest_word[63:0]
	output logic                 m_tlast
);

	ph768_pkg::bstate_t          state_q, state_d;
	ph768_pkg::post_t            post_q;
	ph768_pkg::rate_t            buf_q;
	ph768_pkg::chain_t           chain_q;
	ph768_pkg::perm_t            perm_q;
	ph768_pkg::perm_t            rout;
	ph768_pkg::rate_t            dig_q;
	ph768_pkg::lane_t            ctr_q;
	ph768_pkg::lane_t            tail_word_q;
	logic [3:0]                  pos_q;
	logic [3:0]                  emit_q;
	logic [ph768_pkg::RND_W-1:0] rnd_q;
	logic                        tail_vz_q;
	logic                        exact_q;
	logic                        rnd_end;
	logic                        exact;
	logic                        out_free;
	logic                        m_tvalid_q;

	assign rout     = ph768_pkg::perm_round(perm_q, ph768_pkg::ROUND_KEY[4'(rnd_q)]);
	assign rnd_end  = (rnd_q == ph768_pkg::RND_W'(ph768_pkg::ROUND_COUNT - 1));
	assign exact    = (pos_q == ph768_pkg::POS_EXACT) && tail_vz_q;
	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ph768_pkg::B_IDLE: begin
				if (!q_empty) begin
					if (cmd.full && pos_q == ph768_pkg::POS_LAST) state_d = ph768_pkg::B_CLOAD;
					else if (cmd.last)                           state_d = ph768_pkg::B_TAIL;
				end
			end
			ph768_pkg::B_TAIL: begin
				if (exact)                            state_d = ph768_pkg::B_FLOAD;
				else if (pos_q >= ph768_pkg::POS_EXACT) state_d = ph768_pkg::B_CLOAD;
				else                                  state_d = ph768_pkg::B_FLOAD;
			end
			ph768_pkg::B_CLOAD: state_d = ph768_pkg::B_CROUND;
			ph768_pkg::B_CROUND: begin
				if (rnd_end) begin
					unique case (post_q)
						ph768_pkg::P_TAIL: state_d = ph768_pkg::B_TAIL;
						ph768_pkg::P_CLR:  state_d = ph768_pkg::B_CLR;
						default:           state_d = ph768_pkg::B_IDLE;
					endcase
				end
			end
			ph768_pkg::B_CLR:    state_d = ph768_pkg::B_FLOAD;
			ph768_pkg::B_FLOAD:  state_d = ph768_pkg::B_FROUND;
			ph768_pkg::B_FROUND: if (rnd_end) state_d = ph768_pkg::B_EMIT;
			ph768_pkg::B_EMIT: begin
				if (out_free && emit_q == ph768_pkg::EMIT_LAST) state_d = ph768_pkg::B_IDLE;
			end
			default: state_d = ph768_pkg::B_IDLE;
		endcase
	end

	always_comb begin
		q_pop = (state_q == ph768_pkg::B_IDLE) && !q_empty;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ph768_pkg::B_IDLE;
			post_q     <= ph768_pkg::P_IDLE;
			chain_q    <= ph768_pkg::CHAIN_INIT;
			ctr_q      <= '0;
			pos_q      <= '0;
			emit_q     <= '0;
			rnd_q      <= '0;
			tail_vz_q  <= 1'b0;
			exact_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ph768_pkg::B_EMIT && out_free) m_tvalid_q <= 1'b1;
			else if (m_tready)                            m_tvalid_q <= 1'b0;
			unique case (state_q)
				ph768_pkg::B_IDLE: begin
					if (q_pop) begin
						if (cmd.full) begin
							tail_vz_q <= 1'b1;
							if (pos_q == ph768_pkg::POS_LAST) begin
								pos_q  <= '0;
								post_q <= cmd.last ? ph768_pkg::P_TAIL : ph768_pkg::P_IDLE;
							end else begin
								pos_q <= pos_q + 4'd1;
							end
						end else begin
							tail_vz_q <= cmd.vzero;
						end
					end
				end
				ph768_pkg::B_TAIL: begin
					exact_q <= exact;
					post_q  <= ph768_pkg::P_CLR;
				end
				ph768_pkg::B_CLOAD, ph768_pkg::B_FLOAD: rnd_q <= '0;
				ph768_pkg::B_CROUND: begin
					rnd_q <= rnd_q + 1'b1;
					if (rnd_end) begin
						for (int j = 0; j < ph768_pkg::RATE_WORDS; j++) begin
							chain_q[j]    <= rout[j+1] ^ chain_q[12+j];
							chain_q[12+j] <= rout[13+j] ^ buf_q[j];
						end
						ctr_q <= ctr_q + 64'd1;
					end
				end
				ph768_pkg::B_FROUND: begin
					rnd_q <= rnd_q + 1'b1;
					if (rnd_end) begin
						chain_q <= ph768_pkg::CHAIN_INIT;
						ctr_q   <= '0;
						pos_q   <= '0;
						emit_q  <= '0;
						post_q  <= ph768_pkg::P_IDLE;
					end
				end
				ph768_pkg::B_EMIT: begin
					if (out_free) emit_q <= emit_q + 4'd1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ph768_pkg::B_IDLE: begin
				if (q_pop) begin
					if (cmd.full) begin
						buf_q[pos_q] <= cmd.word;
						tail_word_q  <= ph768_pkg::PAD_BIT;
					end else begin
						tail_word_q  <= cmd.word;
					end
				end
			end
			ph768_pkg::B_TAIL: begin
				if (!exact) begin
					for (int k = 0; k < ph768_pkg::RATE_WORDS; k++) begin
						if (4'(k) == pos_q)     buf_q[k] <= tail_word_q;
						else if (4'(k) > pos_q) buf_q[k] <= '0;
					end
				end
			end
			ph768_pkg::B_CLOAD: begin
				perm_q[0] <= ctr_q;
				for (int j = 0; j < ph768_pkg::RATE_WORDS; j++) begin
					perm_q[1+j]  <= buf_q[j];
					perm_q[13+j] <= chain_q[j];
				end
			end
			ph768_pkg::B_CLR: buf_q <= '0;
			ph768_pkg::B_FLOAD: begin
				perm_q[0] <= exact_q ? ph768_pkg::DOM_EXACT : ph768_pkg::DOM_PADDED;
				for (int k = 0; k < 16; k++) perm_q[1+k]  <= chain_q[8+k];
				for (int k = 0; k < 8; k++)  perm_q[17+k] <= buf_q[k];
			end
			ph768_pkg::B_CROUND: perm_q <= rout;
			ph768_pkg::B_FROUND: begin
				perm_q <= rout;
				if (rnd_end) begin
					for (int k = 0; k < 9; k++)  dig_q[k] <= rout[8+k] ^ chain_q[15+k];
					for (int k = 9; k < 12; k++) dig_q[k] <= rout[8+k] ^ buf_q[k-9];
				end
			end
			ph768_pkg::B_EMIT: begin
				if (out_free) begin
					m_tdata <= dig_q[emit_q];
					m_tlast <= (emit_q == ph768_pkg::EMIT_LAST);
				end
			end
			default: ;
		endcase
	end

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= ph768_pkg::POS_LAST)
		else $error("word position out of range");

	a_fin_to_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ph768_pkg::B_FROUND && rnd_end) |=>
		(state_q == ph768_pkg::B_EMIT && emit_q == 4'd0))
		else $error("finalization did not start digest output");

	a_emit_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ph768_pkg::B_EMIT) |-> (pos_q == 4'd0 && ctr_q == '0))
		else $error("message state not reset during digest output");

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ph768_pkg::B_CROUND || state_q == ph768_pkg::B_FROUND)
		|=> !(state_q == ph768_pkg::B_EMIT && $past(state_q) == ph768_pkg::B_CROUND))
		else $error("compression ran into digest output");

endmodule

`default_nettype wire

@@ hw/rtl/permutation_hash_768.sv @@
// ----------------------------------------------------------------------------
// permutation_hash_768
// 768-bit permutation hash over 64-bit message words with a 12-word digest.
// Throughput: one word per cycle into the rate buffer when the back end idles;
// intake stalls while the round loop compresses each full 12-word block.
// After the last word the tail is padded unless exact, a compression runs if
// needed, then the one-round-per-cycle finalization; the digest follows.
// Reset (arst_n low, asynchronous) resets control, counter and chaining state.
// ----------------------------------------------------------------------------
`default_nettype none

module permutation_hash_768 (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [71:0] s_tdata,   // data_word[63:0], valid_bits[70:64], zero
	input  wire logic        s_tlast,   // last_word
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [63:0]      m_tdata,   // digest_word[63:0]
	output logic             m_tlast    // digest_last
);

	ph768_pkg::cmd_t push_cmd;
	ph768_pkg::cmd_t pop_cmd;
	logic            push;
	logic            pop;
	logic            q_full;
	logic            q_empty;

	ph768_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.q_full   (q_full),
		.q_push   (push),
		.q_cmd    (push_cmd)
	);

	ph768_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.full     (q_full),
		.empty    (q_empty)
	);

	ph768_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (pop_cmd),
		.q_empty  (q_empty),
		.q_pop    (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

`default_nettype wire

@@ test/permutation_hash_768_test.sv @@
// ----------------------------------------------------------------------------
// permutation_hash_768_test
// Streams directed messages and messages of random length and tail into the hash
// core and checks every digest word against a predictor that tracks the chaining state.
// ----------------------------------------------------------------------------
`default_nettype none

module permutation_hash_768_test;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		ph768_pkg::lane_t word;
		logic [6:0]       vbits;
		logic             last;
	} msg_word_t;

	typedef struct {
		ph768_pkg::lane_t word;
		logic             last;
	} digest_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [71:0] s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;
	logic        m_tlast;

	permutation_hash_768 dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	msg_word_t pending_words[$];
	digest_t   expected_digest[$];

	ph768_pkg::chain_t chain_q;
	ph768_pkg::rate_t  rate_q;
	ph768_pkg::lane_t  blk_count;
	int                fill_pos;

	int  errors;
	int  words_sent;
	int  digests_seen;
	int  messages_sent;
	int  cycle_count;
	int  burst_left;
	int  gap_left;
	int  stall_cycles;
	bit  hold_long;
	bit  sender_pause;

	function automatic ph768_pkg::perm_t run_rounds(ph768_pkg::perm_t a);
		ph768_pkg::perm_t b;
		ph768_pkg::perm_t c;
		ph768_pkg::perm_t d;
		ph768_pkg::lane_t p;
		ph768_pkg::lane_t q;
		for (int r = 0; r < ph768_pkg::ROUND_COUNT; r++) begin
			b = a;
			b[0] = b[0] ^ ph768_pkg::ROUND_KEY[r % 16];
			for (int i = 0; i < 5; i++) begin
				c[i] = (b[i] & b[10+i] & b[15+i]) ^ (b[10+i] & b[15+i] & b[20+i])
					^ (b[i] & b[20+i]) ^ (b[15+i] & b[20+i]) ^ b[5+i];
				c[5+i] = (b[5+i] & b[15+i] & b[20+i]) ^ (b[i] & b[5+i]) ^ b[10+i];
				c[10+i] = (b[5+i] & b[10+i]) ^ b[15+i];
				c[15+i] = (b[10+i] & b[15+i]) ^ b[20+i];
				c[20+i] = (b[15+i] & b[20+i]) ^ b[i];
			end
			for (int i = 0; i < 5; i++) begin
				p = '0;
				q = '0;
				for (int j = 0; j < 5; j++) begin
					p = p ^ c[5*i+j];
					q = q ^ ((c[5*i+j] << ph768_pkg::ROT[5*i+j])
						| (c[5*i+j] >> (64 - ph768_pkg::ROT[5*i+j])));
				end
				for (int j = 0; j < 5; j++)
					d[5*i+j] = c[5*i+j] ^ ((p >> ph768_pkg::ROT[5*i+j])
						| (p << (64 - ph768_pkg::ROT[5*i+j]))) ^ q;
			end
			for (int i = 0; i < 5; i++)
				for (int j = 0; j < 5; j++)
					a[5*i+j] = d[((i + 2*j) % 5) * 5 + ((3*i + 3*j) % 5)];
		end
		return a;
	endfunction

	function automatic void start_message();
		chain_q = '0;
		chain_q[23] = ph768_pkg::CHAIN_LEN;
		blk_count = '0;
		fill_pos = 0;
	endfunction

	function automatic void compress_block();
		ph768_pkg::perm_t  st;
		ph768_pkg::chain_t mixv;
		st[0] = blk_count;
		for (int j = 0; j < 12; j++) begin
			st[1+j] = rate_q[j];
			st[13+j] = chain_q[j];
			mixv[j] = chain_q[12+j];
			mixv[12+j] = rate_q[j];
		end
		st = run_rounds(st);
		for (int j = 0; j < 24; j++)
			chain_q[j] = st[j+1] ^ mixv[j];
		blk_count = blk_count + 1;
	endfunction

	function automatic void absorb_word(ph768_pkg::lane_t w);
		rate_q[fill_pos] = w;
		fill_pos++;
		if (fill_pos == 12) begin
			compress_block();
			fill_pos = 0;
		end
	endfunction

	function automatic void predict_hash(msg_word_t it);
		int v;
		bit exact;
		ph768_pkg::lane_t padw;
		ph768_pkg::perm_t st;
		digest_t dg;
		v = it.vbits;
		if (!it.last) begin
			absorb_word(it.word);
			return;
		end
		if (v >= 64) begin
			absorb_word(it.word);
			v = 0;
		end
		exact = (fill_pos == 8 && v == 0);
		if (!exact) begin
			if (v == 0)
				padw = ph768_pkg::PAD_BIT;
			else
				padw = (it.word & ~({64{1'b1}} >> v)) | (ph768_pkg::PAD_BIT >> v);
			rate_q[fill_pos] = padw;
			for (int k = fill_pos + 1; k < 12; k++)
				rate_q[k] = '0;
			if (fill_pos >= 8) begin
				compress_block();
				rate_q = '0;
			end
		end
		st[0] = exact ? ph768_pkg::DOM_EXACT : ph768_pkg::DOM_PADDED;
		for (int k = 0; k < 16; k++)
			st[1+k] = chain_q[8+k];
		for (int k = 0; k < 8; k++)
			st[17+k] = rate_q[k];
		st = run_rounds(st);
		for (int k = 0; k < 12; k++) begin
			dg.word = st[8+k] ^ ((k < 9) ? chain_q[15+k] : rate_q[k-9]);
			dg.last = (k == 11);
			expected_digest.push_back(dg);
		end
		start_message();
	endfunction

	function automatic ph768_pkg::lane_t rand_lane();
		return {$urandom(), $urandom()};
	endfunction

	task automatic queue_message(int full_words, int tail_bits, bit ones);
		msg_word_t it;
		for (int i = 0; i < full_words; i++) begin
			it.word = ones ? '1 : rand_lane();
			it.vbits = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127)) : 7'd64;
			it.last = 1'b0;
			pending_words.push_back(it);
		end
		it.word = ones ? '1 : rand_lane();
		it.vbits = 7'(tail_bits);
		it.last = 1'b1;
		pending_words.push_back(it);
		messages_sent++;
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		int tail;
		arst_n = 1'b0;
		sender_pause = 1'b0;
		messages_sent = 0;
		start_message();
		rate_q = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		// directed: empty, exact 512-bit tail, long tails, full blocks, extremes
		queue_message(0, 0, 0);
		queue_message(8, 0, 0);
		queue_message(7, 64, 0);
		queue_message(9, 5, 1);
		queue_message(11, 63, 0);
		queue_message(11, 64, 1);
		queue_message(0, 127, 1);
		queue_message(2, 1, 0);
		repeat (4000) begin
			@(posedge clk);
			if (pending_words.size() == 0 && expected_digest.size() == 0)
				break;
		end
		sender_pause = 1'b1;
		repeat (40) @(posedge clk);
		sender_pause = 1'b0;
		while (words_sent + pending_words.size() < 460) begin
			tail = $urandom_range(0, 3) == 0 ? $urandom_range(65, 127) : $urandom_range(0, 64);
			queue_message($urandom_range(0, 3) == 0 ? $urandom_range(12, 30)
				: $urandom_range(0, 11), tail, $urandom_range(0, 9) == 0);
			if (messages_sent == 20) begin
				repeat (2000) begin
					@(posedge clk);
					if (pending_words.size() == 0 && expected_digest.size() == 0)
						break;
				end
				sender_pause = 1'b1;
				repeat (40) @(posedge clk);
				sender_pause = 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		msg_word_t it;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tlast <= 1'b0;
			burst_left <= 0;
			gap_left <= 0;
			words_sent <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_hash(pending_words.pop_front());
				words_sent <= words_sent + 1;
			end
			if (s_tvalid && !s_tready) begin
				// hold
			end else if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				s_tvalid <= 1'b0;
			end else if (pending_words.size() > 0 && !sender_pause) begin
				it = pending_words[0];
				s_tvalid <= 1'b1;
				s_tdata <= {1'b0, it.vbits, it.word};
				s_tlast <= it.last;
				if (burst_left == 0) begin
					burst_left <= $urandom_range(1, 30);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_cycles <= 0;
			hold_long <= 1'b0;
		end else if (!hold_long && messages_sent >= 12 && stall_cycles == 0) begin
			hold_long <= 1'b1;
			stall_cycles <= 300;
			m_tready <= 1'b0;
		end else if (stall_cycles > 0) begin
			stall_cycles <= stall_cycles - 1;
			m_tready <= 1'b0;
		end else if (cycle_count % 700 < 250) begin
			m_tready <= 1'b1;
		end else begin
			m_tready <= ($urandom_range(0, 3) != 0);
		end
	end

	always @(posedge clk) begin
		digest_t dg;
		if (arst_n && m_tvalid && m_tready) begin
			digests_seen <= digests_seen + 1;
			if (expected_digest.size() == 0) begin
				$display("%0t: unexpected digest word %h last %b", $time, m_tdata, m_tlast);
				errors <= errors + 1;
			end else begin
				dg = expected_digest.pop_front();
				if (m_tdata !== dg.word || m_tlast !== dg.last) begin
					$display("%0t: digest mismatch expected %h/%b actual %h/%b",
						$time, dg.word, dg.last, m_tdata, m_tlast);
					errors <= errors + 1;
				end
			end
		end
	end

	initial begin
		errors = 0;
		digests_seen = 0;
		cycle_count = 0;
		@(posedge arst_n);
		while (!(words_sent >= 460 && pending_words.size() == 0 && !s_tvalid
				&& expected_digest.size() == 0) && cycle_count < 400000) begin
			@(posedge clk);
			cycle_count++;
		end
		if (cycle_count >= 400000) begin
			$display("timeout with %0d digest words outstanding", expected_digest.size());
			$display("simulation failed");
			$finish;
		end else begin
			repeat (60) @(posedge clk);
			$display("covered %0d messages, %0d input words, %0d digest words",
				messages_sent, words_sent, digests_seen);
			if (errors == 0 && expected_digest.size() == 0)
				$display("simulation ok");
			else
				$display("simulation failed");
			$finish;
		end
	end

endmodule

`default_nettype wire
